@@ src/cfr_pkg.sv @@
// Shared types and constants for the chunk frame receiver.
// Used by cfr_front, cfr_queue, cfr_back and the top level.
`default_nettype none

package cfr_pkg;

    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned COUNT_W      = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [7:0] TYPE_DATA  = 8'h01;
    localparam logic [7:0] MSG_UPLOAD = 8'h0D;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_BAD_TYPE   = 3'd3,
        ST_LEN_MISM   = 3'd4,
        ST_BAD_CHKSUM = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        DISP_COMMAND  = 2'd0,
        DISP_UPLOAD   = 2'd1,
        DISP_CONTINUE = 2'd2,
        DISP_EMPTY    = 2'd3
    } dispatch_t;

    // One queued job: an optional payload transfer followed by an optional verdict.
    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        verd_valid;
        status_t     status;
        logic [7:0]  chunk_id;
        logic [7:0]  chunk_number;
        logic [7:0]  chunk_total;
        logic [15:0] data_length;
        logic        is_chunked;
        dispatch_t   dispatch;
        logic [7:0]  message_type;
    } job_t;

    // Output tdata layout, lowest field last.
    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  message_type;
        dispatch_t   dispatch;
        logic        is_chunked;
        logic [15:0] data_length;
        logic [7:0]  chunk_total;
        logic [7:0]  chunk_number;
        logic [7:0]  chunk_id;
        status_t     status;
        logic [7:0]  payload_byte;
    } out_word_t;

endpackage

`default_nettype wire

@@ src/cfr_front.sv @@
// Front end: takes received bytes, tracks header, count and XOR, builds jobs.
// Depends on cfr_pkg.
`default_nettype none

module cfr_front
    import cfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       q_full,
    output logic            q_push,
    output job_t            q_data
);

    logic [7:0]         magic_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         xor_reg, xor_next;
    logic [7:0]         hdr_reg  [HEADER_BYTES];
    logic [7:0]         hdr_next [HEADER_BYTES];
    logic [7:0]         check_reg, check_next;
    logic               seen_reg, seen_next;
    logic [7:0]         first_reg, first_next;

    logic               accept;
    logic               in_hdr;
    logic [COUNT_W-1:0] off;
    logic [15:0]        plen_cur;
    logic [15:0]        plen_new;
    logic               is_pay;
    logic               is_chk;
    logic [COUNT_W-1:0] len_need;
    status_t            status;
    logic               chunked;
    dispatch_t          disp;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        plen_cur = {hdr_reg[6], hdr_reg[5]};
        in_hdr   = count_reg < COUNT_W'(HEADER_BYTES);
        off      = count_reg - COUNT_W'(HEADER_BYTES);
        is_pay   = !in_hdr && (off < {1'b0, plen_cur});
        is_chk   = !in_hdr && (off == {1'b0, plen_cur}) && !seen_reg;

        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            hdr_next[i] = (in_hdr && count_reg[2:0] == 3'(i)) ? in_byte : hdr_reg[i];
        end
        xor_next   = xor_reg ^ ((in_hdr || is_pay) ? in_byte : 8'h00);
        first_next = (is_pay && off == '0) ? in_byte : first_reg;
        check_next = is_chk ? in_byte : check_reg;
        seen_next  = seen_reg || is_chk;
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

        plen_new = {hdr_next[6], hdr_next[5]};
        len_need = COUNT_W'(plen_new) + COUNT_W'(HEADER_BYTES + 1);

        if (count_next < COUNT_W'(HEADER_BYTES + 1))
            status = ST_TOO_SHORT;
        else if (hdr_next[0] != magic_reg)
            status = ST_BAD_MAGIC;
        else if (hdr_next[1] != TYPE_DATA)
            status = ST_BAD_TYPE;
        else if (count_next < len_need)
            status = ST_LEN_MISM;
        else if (check_next != xor_next)
            status = ST_BAD_CHKSUM;
        else
            status = ST_OK;

        chunked = 1'b0;
        disp    = DISP_COMMAND;
        if (status == ST_OK)
        begin
            chunked = hdr_next[4] > 8'd1;
            if (chunked)
            begin
                if (plen_new != '0 && first_next == MSG_UPLOAD)
                    disp = DISP_UPLOAD;
                else if (hdr_next[3] == 8'd1)
                    disp = (plen_new == '0) ? DISP_EMPTY : DISP_COMMAND;
                else
                    disp = DISP_CONTINUE;
            end
            else
            begin
                if (plen_new == '0)
                    disp = DISP_EMPTY;
                else if (first_next == MSG_UPLOAD)
                    disp = DISP_UPLOAD;
                else
                    disp = DISP_COMMAND;
            end
        end

        q_push              = accept && (is_pay || in_last);
        q_data.pay_valid    = is_pay;
        q_data.pay_byte     = in_byte;
        q_data.verd_valid   = in_last;
        q_data.status       = status;
        q_data.chunk_id     = hdr_next[2];
        q_data.chunk_number = hdr_next[3];
        q_data.chunk_total  = hdr_next[4];
        q_data.data_length  = plen_new;
        q_data.is_chunked   = chunked;
        q_data.dispatch     = disp;
        q_data.message_type = first_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            magic_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            xor_reg   <= '0;
            check_reg <= '0;
            seen_reg  <= 1'b0;
            first_reg <= '0;
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (in_last)
            begin
                count_reg <= '0;
                xor_reg   <= '0;
                check_reg <= '0;
                seen_reg  <= 1'b0;
                first_reg <= '0;
                for (int i = 0; i < HEADER_BYTES; i++)
                begin
                    hdr_reg[i] <= '0;
                end
            end
            else
            begin
                count_reg <= count_next;
                xor_reg   <= xor_next;
                check_reg <= check_next;
                seen_reg  <= seen_next;
                first_reg <= first_next;
                for (int i = 0; i < HEADER_BYTES; i++)
                begin
                    hdr_reg[i] <= hdr_next[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ src/cfr_queue.sv @@
// Small job queue between the front end and the result stage.
// Depends on cfr_pkg for the job type.
`default_nettype none

module cfr_queue
    import cfr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ src/cfr_back.sv @@
// Result stage: turns queued jobs into payload and verdict transfers.
// Depends on cfr_pkg; drives the output register of the block.
`default_nettype none

module cfr_back
    import cfr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_empty,
    input  wire job_t   q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [63:0] out_data,
    output logic        out_kind,
    output logic        out_last
);

    logic      valid_reg;
    logic      phase_reg, phase_next;
    out_word_t word_reg, word_next;
    logic      kind_reg, kind_next;
    logic      last_reg, last_next;
    logic      load;
    logic      emit_pay;

    always_comb
    begin
        load     = !q_empty && (!valid_reg || out_ready);
        emit_pay = q_head.pay_valid && !phase_reg;
        q_pop    = load && (emit_pay ? !q_head.verd_valid : 1'b1);
        phase_next = phase_reg;
        if (load)
            phase_next = emit_pay && q_head.verd_valid;

        word_next = '0;
        if (emit_pay)
        begin
            word_next.payload_byte = q_head.pay_byte;
            kind_next = 1'b0;
            last_next = !q_head.verd_valid;
        end
        else
        begin
            word_next.status       = q_head.status;
            word_next.chunk_id     = q_head.chunk_id;
            word_next.chunk_number = q_head.chunk_number;
            word_next.chunk_total  = q_head.chunk_total;
            word_next.data_length  = q_head.data_length;
            word_next.is_chunked   = q_head.is_chunked;
            word_next.dispatch     = q_head.dispatch;
            word_next.message_type = q_head.message_type;
            kind_next = 1'b1;
            last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
            kind_reg <= kind_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = word_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

@@ src/chunk_frame_receiver.sv @@
// Top level of the chunk frame receiver: front end, job queue and result stage.
// Depends on cfr_pkg, cfr_front, cfr_queue and cfr_back.
//
// Takes one message byte per cycle on the slave stream while tready is high, tlast on
// the final byte. Each payload byte is forwarded as a transfer; the final byte also
// yields a verdict transfer (status, header fields, dispatch), so a final byte that
// is payload gives two output transfers. The front end updates header, count and
// XOR as each byte is taken; results pass through the queue slot and the output
// register. A queue of QUEUE_DEPTH jobs lets input keep flowing while the output
// is held; tready drops only when it fills. The user must write magic_value through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce it.
`default_nettype none

module chunk_frame_receiver
    import cfr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // magic_value
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic        s_axis_tlast,  // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] payload_byte, [10:8] status, [18:11] chunk_id, [26:19] chunk_number,
    // [34:27] chunk_total, [50:35] data_length, [51] is_chunked, [53:52] dispatch,
    // [61:54] message_type, [63:62] zero
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tuser,  // kind
    output logic             m_axis_tlast   // last_result
);

    logic q_push, q_full, q_pop, q_empty;
    job_t q_in, q_head;

    cfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    cfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    cfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ src/chunk_frame_receiver_chk.sv @@
// Port-level checker for chunk_frame_receiver, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module chunk_frame_receiver_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // payload transfers carry nothing but the byte
    a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:8] == '0)
        else $error("payload transfer has verdict bits set");

    a_verd_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == '0)
        else $error("verdict transfer not last or has payload byte");

    a_fail_nodisp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[10:8] != 3'd0
        |-> m_axis_tdata[53:51] == 3'd0)
        else $error("failed verdict carries dispatch");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[10:8] <= 3'd5)
        else $error("status out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind chunk_frame_receiver chunk_frame_receiver_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
